### hw/rtl/median_presence_detector_macros.svh
// Assertion macros shared by the median presence detector RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef MEDIAN_PRESENCE_DETECTOR_MACROS_SVH
`define MEDIAN_PRESENCE_DETECTOR_MACROS_SVH

// Check a property on every clock edge outside reset
`define MPD_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included
`define MPD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mpd_pkg.sv
// Shared constants for the median presence detector.
// No dependencies; used by every module of the block.
package mpd_pkg;

  // Width of a distance sample in millimetres
  localparam int DIST_W = 16;

  // Default window length
  localparam int WINDOW_DEFAULT = 5;

  // Presence threshold after reset
  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd22;

endpackage

### hw/rtl/mpd_window.sv
// Sample window store: fill count, oldest-slot pointer and sample registers.
// Depends on mpd_pkg and the assertion macros header.
`include "median_presence_detector_macros.svh"

module mpd_window #(
  parameter int WINDOW = mpd_pkg::WINDOW_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [mpd_pkg::DIST_W-1:0]            sample,
  output logic                                  full,
  output logic [WINDOW-1:0][mpd_pkg::DIST_W-1:0] win_nxt
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = $clog2(WINDOW);

  logic [WINDOW-1:0][mpd_pkg::DIST_W-1:0] win_r;
  logic [CW-1:0]                          fill_count_r;
  logic [CW-1:0]                          fill_count_nxt;
  logic [SW-1:0]                          oldest_slot_r;
  logic [SW-1:0]                          oldest_slot_nxt;
  logic [SW-1:0]                          wr_slot;

  assign full    = (fill_count_r == CW'(WINDOW));
  assign wr_slot = full ? oldest_slot_r : fill_count_r[SW-1:0];

  // Window as it stands once the new request's sample is written
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_nxt[i] = (wr_slot == SW'(i)) ? sample : win_r[i];
    end
  end

  // Advance fill count while filling, then rotate the oldest slot
  always_comb begin
    fill_count_nxt  = fill_count_r;
    oldest_slot_nxt = oldest_slot_r;
    if (!full) begin
      fill_count_nxt = fill_count_r + 1'b1;
    end else if (oldest_slot_r == SW'(WINDOW - 1)) begin
      oldest_slot_nxt = '0;
    end else begin
      oldest_slot_nxt = oldest_slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r  <= '0;
      oldest_slot_r <= '0;
    end else if (load) begin
      fill_count_r  <= fill_count_nxt;
      oldest_slot_r <= oldest_slot_nxt;
    end
  end

  // Sample storage, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      win_r <= win_nxt;
    end
  end

  `MPD_ASSERT_CLK(a_fill_bound, fill_count_r <= CW'(WINDOW), "fill count beyond window")
  `MPD_ASSERT_CLK(a_full_sticks, full |=> full, "window left the full state")
  `MPD_ASSERT_CLK(a_slot_idle, !full |-> oldest_slot_r == '0, "oldest slot moved while filling")

endmodule

### hw/rtl/mpd_median.sv
// Rank-compare median selector over a full window of samples.
// Depends on mpd_pkg.
module mpd_median #(
  parameter int WINDOW = mpd_pkg::WINDOW_DEFAULT
) (
  input  logic [WINDOW-1:0][mpd_pkg::DIST_W-1:0] win,
  output logic [mpd_pkg::DIST_W-1:0]             median
);

  localparam int              RW  = $clog2(WINDOW);
  localparam logic [RW-1:0]   MID = RW'(WINDOW / 2);

  logic [WINDOW-1:0][RW-1:0] rank;

  // Rank each sample; equal values are ordered by slot so ranks are unique
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      rank[k] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != k) begin
          rank[k] = rank[k] + RW'((win[j] < win[k]) || ((win[j] == win[k]) && (j < k)));
        end
      end
    end
  end

  // Pick the sample whose rank is the middle one
  always_comb begin
    median = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (rank[k] == MID) begin
        median = median | win[k];
      end
    end
  end

endmodule

### hw/rtl/median_presence_detector.sv
// Median presence detector: sliding-window median of distance samples with a
// presence threshold and edge pulses. A request enters the input register on
// in_valid & in_ready and moves on to the output register once that is free or
// being emptied, where out_valid holds it until out_ready takes it.
// Throughput: one request per cycle unless the receiver stalls; the path between
// the two registers is the window update plus the WINDOW x WINDOW rank-compare
// network and its select.
// The first WINDOW requests pass their raw sample through (out_window_full 0);
// from then on the output is the median of the last WINDOW samples.
// out_object_present is 1 when the filtered distance is at or below the
// threshold; out_detect_pulse and out_remove_pulse mark its changes.
// cfg_data writes the threshold (cfg_ready is always high); write it only
// while no request is in flight.
// Reset (rst_n low, synchronous) empties both registers, clears the window
// fill state and the presence history, and sets the threshold to 22 mm.
// When the receiver stalls, the output holds and the input register drains
// into it as soon as it frees; in_ready drops while both are occupied and
// out_ready is low.
// Depends on mpd_pkg, mpd_window, mpd_median and the assertion macros header.
`include "median_presence_detector_macros.svh"

module median_presence_detector #(
  parameter int WINDOW = mpd_pkg::WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mpd_pkg::DIST_W-1:0] in_raw_distance,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mpd_pkg::DIST_W-1:0] out_filtered_distance,
  output logic                       out_window_full,
  output logic                       out_object_present,
  output logic                       out_detect_pulse,
  output logic                       out_remove_pulse,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mpd_pkg::DIST_W-1:0] cfg_data
);

  logic                                   s1_valid_r;
  logic [mpd_pkg::DIST_W-1:0]             s1_sample_r;
  logic                                   s1_adv;
  logic                                   out_valid_r;
  logic [mpd_pkg::DIST_W-1:0]             filt_r;
  logic                                   full_r;
  logic                                   present_r;
  logic                                   detect_r;
  logic                                   remove_r;
  logic                                   was_present_r;
  logic [mpd_pkg::DIST_W-1:0]             threshold_r;
  logic                                   win_full;
  logic [WINDOW-1:0][mpd_pkg::DIST_W-1:0] win_nxt;
  logic [mpd_pkg::DIST_W-1:0]             median;
  logic [mpd_pkg::DIST_W-1:0]             filt;
  logic                                   present;

  // Handshake: move stage 1 on whenever the output register is free or out_ready empties it
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= mpd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r <= in_raw_distance;
    end
  end

  mpd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_adv),
    .sample  (s1_sample_r),
    .full    (win_full),
    .win_nxt (win_nxt)
  );

  mpd_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .win    (win_nxt),
    .median (median)
  );

  // Pass the raw sample until the window is full, then the median
  assign filt    = win_full ? median : s1_sample_r;
  assign present = (filt <= threshold_r);

  // Output register and presence history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      was_present_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_r   <= 1'b1;
        was_present_r <= present;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      filt_r    <= filt;
      full_r    <= win_full;
      present_r <= present;
      detect_r  <= present && !was_present_r;
      remove_r  <= !present && was_present_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_filtered_distance = filt_r;
  assign out_window_full       = full_r;
  assign out_object_present    = present_r;
  assign out_detect_pulse      = detect_r;
  assign out_remove_pulse      = remove_r;

  `MPD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "not empty after reset")
  `MPD_ASSERT_CLK(a_detect_present, out_valid_r && detect_r |-> present_r, "detect without presence")
  `MPD_ASSERT_CLK(a_remove_absent, out_valid_r && remove_r |-> !present_r, "remove with presence")
  `MPD_ASSERT_CLK(a_history, s1_adv |=> was_present_r == present_r, "presence history out of step")

endmodule
